// ===== hdl/smda_pkg.sv =====
// Shared constants, types and exponent table for the soft-argmin disparity block.
package smda_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
  localparam int IDX_W          = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int NUM_BANKS      = 2;
  localparam int BANK_W         = 1;
  localparam int RAM_ADDR_W     = IDX_W + BANK_W;
  localparam int RAM_DEPTH      = 1 << RAM_ADDR_W;
  localparam int QUEUE_DEPTH    = NUM_BANKS;
  localparam int QPTR_W         = 1;

  localparam int COST_W   = 16;
  localparam int DISP_W   = 16;
  localparam int EXP_BITS = 12;
  localparam int ACC_W    = 33;
  localparam int W_W      = 17;
  localparam int PROD_W   = W_W + DISP_W;
  localparam int NUM_W    = PROD_W + CNT_W;
  localparam int DEN_W    = W_W + CNT_W;
  localparam int QUO_W    = 17;
  localparam int DCNT_W   = $clog2(QUO_W + 1);

  // Q0.32 factors for exp(-2^k/256)
  localparam logic [31:0] EXP_FACTOR [EXP_BITS] = '{
    32'd4278222848, 32'd4261543594, 32'd4228380008, 32'd4162825042,
    32'd4034748383, 32'd3790295337, 32'd3344923893, 32'd2605029253,
    32'd1580030166, 32'd581260615,  32'd78665071,   32'd1440796
  };

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [CNT_W-1:0]  count;
    logic [COST_W-1:0] lowest;
    logic              ovf;
  } job_t;

endpackage

// ===== hdl/smda_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smda_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/smda_front.sv =====
// Front end: accepts candidates, fills the store bank, tracks lowest cost.
module smda_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [smda_pkg::COST_W-1:0]          cand_cost,
  input  logic                                 last_candidate,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  output logic                                 wr_en,
  output logic [smda_pkg::RAM_ADDR_W-1:0]      wr_addr,
  output logic                                 job_push,
  output smda_pkg::job_t                       job,
  input  logic                                 bank_release
);
  import smda_pkg::*;

  localparam int OUT_W = $clog2(NUM_BANKS + 1);

  logic [CNT_W-1:0]  count, count_next;
  logic [COST_W-1:0] lowest, lowest_next;
  logic              ovf, ovf_next;
  logic [BANK_W-1:0] bank;
  logic [OUT_W-1:0]  outstanding;
  logic              xfer, stored;

  assign in_stall = (outstanding == OUT_W'(NUM_BANKS));
  assign xfer     = in_valid && !in_stall;
  assign stored   = xfer && (count < CNT_W'(MAX_CANDIDATES));
  assign wr_en    = stored;
  assign wr_addr  = {bank, count[IDX_W-1:0]};
  assign job_push = xfer && last_candidate;

  always_comb begin
    count_next  = stored ? count + CNT_W'(1) : count;
    lowest_next = (stored && (cand_cost < lowest)) ? cand_cost : lowest;
    ovf_next    = ovf || (xfer && !stored);
    job.bank    = bank;
    job.count   = count_next;
    job.lowest  = lowest_next;
    job.ovf     = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      lowest      <= '1;
      ovf         <= 1'b0;
      bank        <= '0;
      outstanding <= '0;
    end else begin
      if (job_push) begin
        count  <= '0;
        lowest <= '1;
        ovf    <= 1'b0;
        bank   <= bank + BANK_W'(1);
      end else begin
        count  <= count_next;
        lowest <= lowest_next;
        ovf    <= ovf_next;
      end
      case ({job_push, bank_release})
        2'b10:   outstanding <= outstanding + OUT_W'(1);
        2'b01:   outstanding <= outstanding - OUT_W'(1);
        default: outstanding <= outstanding;
      endcase
    end
  end

endmodule

// ===== hdl/smda_queue.sv =====
// Short job queue between front end and back end.
module smda_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  smda_pkg::job_t push_job,
  input  logic           pop,
  output smda_pkg::job_t pop_job,
  output logic           not_empty
);
  import smda_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign not_empty = (fill != '0);
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W + 1)'(1);
        2'b01:   fill <= fill - (QPTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/smda_div.sv =====
// Rounded signed divide of the weighted sum, one quotient bit per cycle.
module smda_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [smda_pkg::NUM_W-1:0]   num,
  input  logic [smda_pkg::DEN_W-1:0]          den,
  output logic                                done,
  output logic signed [smda_pkg::DISP_W-1:0]  quo
);
  import smda_pkg::*;

  localparam logic signed [QUO_W:0] Q_MAX = (QUO_W + 1)'(32767);
  localparam logic signed [QUO_W:0] Q_MIN = (QUO_W + 1)'(-32768);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DEN_W-1:0]  rem, den_r;
  logic [QUO_W-1:0]  qsh;
  logic              neg, den_zero;
  logic [NUM_W-1:0]  mag;
  logic [NUM_W:0]    nsum;
  logic [DEN_W:0]    part, trial;
  logic              ge;
  logic signed [QUO_W:0] sq;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign nsum  = {1'b0, mag} + (NUM_W + 1)'(den >> 1);
  assign part  = {rem, qsh[QUO_W-1]};
  assign ge    = (part >= {1'b0, den_r});
  assign trial = part - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= DEN_W'(nsum >> QUO_W);
      qsh      <= nsum[QUO_W-1:0];
      den_r    <= den;
      neg      <= num[NUM_W-1];
      den_zero <= (den == '0);
    end else if (busy) begin
      rem <= ge ? trial[DEN_W-1:0] : part[DEN_W-1:0];
      qsh <= {qsh[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DCNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    sq = neg ? -$signed({1'b0, qsh}) : $signed({1'b0, qsh});
    if (den_zero) begin
      quo = '0;
    end else if (sq > Q_MAX) begin
      quo = Q_MAX[DISP_W-1:0];
    end else if (sq < Q_MIN) begin
      quo = Q_MIN[DISP_W-1:0];
    end else begin
      quo = sq[DISP_W-1:0];
    end
  end

endmodule

// ===== hdl/smda_back.sv =====
// Back end: walks a stored pixel, weights candidates, accumulates and divides.
module smda_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  input  smda_pkg::job_t                      job_in,
  output logic                                job_pop,
  output logic [smda_pkg::RAM_ADDR_W-1:0]     rd_addr,
  input  logic [smda_pkg::COST_W-1:0]         cost_rd,
  input  logic signed [smda_pkg::DISP_W-1:0]  disp_rd,
  output logic                                bank_release,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [smda_pkg::DISP_W-1:0]  refined_disparity,
  output logic                                dropped_flag
);
  import smda_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [ACC_W-1:0] ACC_ONE  = ACC_W'(64'h1_0000_0000);
  localparam logic [ACC_W-1:0] W_ROUND  = ACC_W'(32'h8000);
  localparam logic [2*ACC_W-2:0] M_ROUND = (2 * ACC_W - 1)'(64'h8000_0000);

  logic [2:0]       state;
  job_t             job;
  logic [CNT_W-1:0] idx;
  logic [CNT_W:0]   idx_inc;
  logic             rd_en, rd_vld, walk_end;

  logic [COST_W-1:0] diff;
  logic [ACC_W-1:0]          acc_p  [EXP_BITS+1];
  logic [EXP_BITS-1:0]       d_p    [EXP_BITS+1];
  logic                      big_p  [EXP_BITS+1];
  logic signed [DISP_W-1:0]  disp_p [EXP_BITS+1];
  logic                      vld_p  [EXP_BITS+1];

  logic [ACC_W-1:0]         wsum;
  logic [W_W-1:0]           w_q, w_m;
  logic signed [DISP_W-1:0] disp_w;
  logic                     w_vld, m_vld;
  logic signed [PROD_W:0]   prod_full;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic                    vld_any;
  logic                    div_start, div_done;
  logic signed [DISP_W-1:0] div_quo;

  assign idx_inc      = {1'b0, idx} + (CNT_W + 1)'(1);
  assign rd_en        = (state == S_WALK) && (idx < job.count);
  assign walk_end     = (state == S_WALK) && (idx_inc >= {1'b0, job.count});
  assign bank_release = walk_end;
  assign rd_addr      = {job.bank, idx[IDX_W-1:0]};
  assign job_pop      = (state == S_IDLE) && job_valid;
  assign out_valid    = (state == S_OUT);
  assign diff         = cost_rd - job.lowest;

  always_comb begin
    vld_any = rd_vld || w_vld || m_vld;
    for (int k = 0; k <= EXP_BITS; k++) begin
      vld_any = vld_any || vld_p[k];
    end
  end

  assign div_start = (state == S_DRAIN) && !vld_any;

  // weight pipeline: one stage per exponent bit
  always_ff @(posedge clk) begin
    acc_p[0]  <= ACC_ONE;
    d_p[0]    <= diff[EXP_BITS-1:0];
    big_p[0]  <= (diff[COST_W-1:EXP_BITS] != '0);
    disp_p[0] <= disp_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      vld_p[0] <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      vld_p[0] <= rd_vld;
    end
  end

  for (genvar k = 0; k < EXP_BITS; k++) begin : g_exp
    logic [2*ACC_W-2:0] mul;
    assign mul = (2 * ACC_W - 1)'(acc_p[k]) * (2 * ACC_W - 1)'(EXP_FACTOR[k]) + M_ROUND;

    always_ff @(posedge clk) begin
      acc_p[k+1]  <= d_p[k][k] ? mul[2*ACC_W-2:32] : acc_p[k];
      d_p[k+1]    <= d_p[k];
      big_p[k+1]  <= big_p[k];
      disp_p[k+1] <= disp_p[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_p[k+1] <= 1'b0;
      end else begin
        vld_p[k+1] <= vld_p[k];
      end
    end
  end

  assign wsum      = acc_p[EXP_BITS] + W_ROUND;
  assign prod_full = $signed({1'b0, w_q}) * disp_w;

  always_ff @(posedge clk) begin
    w_q    <= big_p[EXP_BITS] ? '0 : wsum[ACC_W-1:16];
    disp_w <= disp_p[EXP_BITS];
    prod_q <= prod_full[PROD_W-1:0];
    w_m    <= w_q;
    if (job_pop) begin
      num <= '0;
      den <= '0;
    end else if (m_vld) begin
      num <= num + {{(NUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
      den <= den + DEN_W'(w_m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld <= 1'b0;
      m_vld <= 1'b0;
    end else begin
      w_vld <= vld_p[EXP_BITS];
      m_vld <= w_vld;
    end
  end

  smda_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end
    if (state == S_DIV && div_done) begin
      refined_disparity <= div_quo;
      dropped_flag      <= job.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (job_valid) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_en) begin
            idx <= idx + CNT_W'(1);
          end
          if (walk_end) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !vld_any)
    else $error("weight pipeline busy while idle");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");
  a_release_once: assert property (@(posedge clk) disable iff (rst)
    bank_release |=> !bank_release)
    else $error("bank released twice");
  a_out_drained: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!vld_any && !rd_en))
    else $error("result presented while walk still active");
`endif

endmodule

// ===== hdl/soft_min_disparity_average.sv =====
// Top level of the soft-argmin sub-pixel disparity block.
//
// Input channel: one candidate per transfer (cand_cost, cand_disparity,
// last_candidate), taken at a clock edge with in_valid high and in_stall low.
// Candidates are written to one of two store banks at one per cycle while in_stall
// is low; when the marked last candidate arrives the pixel is handed to the back
// end and loading of the next pixel starts at once in the other bank. in_stall
// rises only while both banks still hold pixels not yet walked.
// Output channel: one result per pixel (refined_disparity, dropped_flag),
// taken with out_valid high and out_stall low. A stalled result holds; the
// front end keeps loading meanwhile.
// From the last candidate to the result, a pixel passes through one store read
// per stored candidate, a weight and multiply-accumulate pipeline, and a 17-bit
// quotient loop. The back end works on one pixel at a time, so its time per pixel
// sets the sustained rate; candidates beyond 64 per pixel are dropped and flagged.
// Reset (rst, synchronous) empties both banks and the job queue and clears
// the running count, lowest cost and drop flag.
module soft_min_disparity_average (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [smda_pkg::COST_W-1:0]         cand_cost,
  input  logic signed [smda_pkg::DISP_W-1:0]  cand_disparity,
  input  logic                                last_candidate,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic signed [smda_pkg::DISP_W-1:0]  refined_disparity,
  output logic                                dropped_flag,
  output logic                                out_valid,
  input  logic                                out_stall
);
  import smda_pkg::*;

  logic                  wr_en;
  logic [RAM_ADDR_W-1:0] wr_addr, rd_addr;
  logic                  job_push, job_pop, job_valid, bank_release;
  job_t                  push_job, pop_job;
  logic [COST_W-1:0]     cost_rd;
  logic [DISP_W-1:0]     disp_rd;

  smda_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cand_cost     (cand_cost),
    .last_candidate(last_candidate),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .job_push      (job_push),
    .job           (push_job),
    .bank_release  (bank_release)
  );

  smda_ram #(.WIDTH(COST_W), .DEPTH(RAM_DEPTH)) u_cost_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(cand_cost),
    .rd_addr(rd_addr),
    .rd_data(cost_rd)
  );

  smda_ram #(.WIDTH(DISP_W), .DEPTH(RAM_DEPTH)) u_disp_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(cand_disparity),
    .rd_addr(rd_addr),
    .rd_data(disp_rd)
  );

  smda_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .not_empty(job_valid)
  );

  smda_back u_back (
    .clk              (clk),
    .rst              (rst),
    .job_valid        (job_valid),
    .job_in           (pop_job),
    .job_pop          (job_pop),
    .rd_addr          (rd_addr),
    .cost_rd          (cost_rd),
    .disp_rd          (disp_rd),
    .bank_release     (bank_release),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .refined_disparity(refined_disparity),
    .dropped_flag     (dropped_flag)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for soft_min_disparity_average with a built-in soft-argmin predictor.
`timescale 1ns / 100ps

module tb_top;
  import smda_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 120;

  typedef enum {SPREAD_NARROW, SPREAD_EDGE, SPREAD_WIDE} spread_e;

  typedef struct {
    logic [COST_W-1:0]        cost;
    logic signed [DISP_W-1:0] disp;
    logic                     last;
    logic                     hold;
  } cand_t;

  typedef struct {
    logic signed [DISP_W-1:0] disp;
    logic                     dropped;
  } pixel_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic [COST_W-1:0]        cand_cost = '0;
  logic signed [DISP_W-1:0] cand_disparity = '0;
  logic                     last_candidate = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DISP_W-1:0] refined_disparity;
  logic                     dropped_flag;
  logic                     out_valid;
  logic                     out_stall = 1'b0;

  cand_t         pending[$];
  pixel_result_t pixel_results[$];

  logic [COST_W-1:0]        held_cost[MAX_CANDIDATES];
  logic signed [DISP_W-1:0] held_disp[MAX_CANDIDATES];
  int                       held_count = 0;
  logic [COST_W-1:0]        lowest_held = '1;
  logic                     dropped_seen = 1'b0;

  int          gap_left = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [31:0] cycle_no = '0;
  int          mismatches = 0;
  int          results_checked = 0;
  int          dropped_results = 0;
  int          total_cands = 0;
  int          pixels = 0;
  int          overfull_pixels = 0;

  soft_min_disparity_average uut (
    .clk               (clk),
    .rst               (rst),
    .cand_cost         (cand_cost),
    .cand_disparity    (cand_disparity),
    .last_candidate    (last_candidate),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .refined_disparity (refined_disparity),
    .dropped_flag      (dropped_flag),
    .out_valid         (out_valid),
    .out_stall         (out_stall)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // exp(-d/256) in Q1.16, built bit by bit from the Q0.32 factors
  function automatic logic [16:0] exp_weight(logic [COST_W-1:0] d);
    logic [63:0] acc;
    acc = 64'd1 << 32;
    if (d >= 16'd4096) return '0;
    for (int k = 0; k < EXP_BITS; k++) begin
      if (d[k]) acc = (acc * 64'(EXP_FACTOR[k]) + (64'd1 << 31)) >> 32;
    end
    return 17'((acc + 64'd32768) >> 16);
  endfunction

  task automatic absorb_candidate(logic [COST_W-1:0] cost, logic signed [DISP_W-1:0] disp,
                                  logic last);
    longint num;
    longint den;
    longint q;
    longint w;
    pixel_result_t res;
    num = 0;
    den = 0;
    if (held_count < MAX_CANDIDATES) begin
      held_cost[held_count] = cost;
      held_disp[held_count] = disp;
      held_count++;
      if (cost < lowest_held) lowest_held = cost;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!last) return;
    for (int i = 0; i < held_count; i++) begin
      w = longint'(exp_weight(held_cost[i] - lowest_held));
      num += w * longint'(held_disp[i]);
      den += w;
    end
    if (den <= 0) q = 0;
    else if (num >= 0) q = (num + den / 2) / den;
    else q = -((-num + den / 2) / den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res.disp = DISP_W'(q);
    res.dropped = dropped_seen;
    pixel_results.push_back(res);
    held_count = 0;
    lowest_held = '1;
    dropped_seen = 1'b0;
  endtask

  task automatic push_cand(logic [COST_W-1:0] cost, logic signed [DISP_W-1:0] disp,
                           logic last, logic hold);
    cand_t c;
    c.cost = cost;
    c.disp = disp;
    c.last = last;
    c.hold = hold;
    pending.push_back(c);
    total_cands++;
  endtask

  task automatic note_mismatch(string field, int got, int want);
    $display("Mismatch on %s at %0t: got %0d, want %0d", field, $time, got, want);
    mismatches++;
  endtask

  function automatic bit calm_now();
    return pending.size() < 80 || cycle_no[9:8] == 2'b11;
  endfunction

  // Driver
  always @(posedge clk) begin
    cand_t c;
    logic  nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_candidate(cand_cost, cand_disparity, last_candidate);
      if (!in_valid || !in_stall) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending.size() != 0 &&
                     !(pending[0].hold && pixel_results.size() != 0)) begin
          c = pending.pop_front();
          cand_cost <= c.cost;
          cand_disparity <= c.disp;
          last_candidate <= c.last;
          nv = 1'b1;
          if (!calm_now() && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 16);
        end
        in_valid <= nv;
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_results.size() == 0) begin
          note_mismatch("unexpected result", refined_disparity, 0);
        end else begin
          want = pixel_results.pop_front();
          if (refined_disparity !== want.disp)
            note_mismatch("refined_disparity", refined_disparity, want.disp);
          if (dropped_flag !== want.dropped)
            note_mismatch("dropped_flag", dropped_flag, want.dropped);
          results_checked++;
          if (want.dropped) dropped_results++;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm_now() && $urandom_range(0, 15) == 0) begin
        stall_left <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int                       r;
    int                       len;
    spread_e                  spread;
    logic [COST_W-1:0]        base;
    logic [COST_W-1:0]        cost;

    // directed pixels
    push_cand(16'h0000, 16'sh7FFF, 1'b1, 1'b0);
    push_cand(16'hFFFF, -16'sh8000, 1'b1, 1'b0);
    push_cand(16'h0000, 16'sh7FFF, 1'b0, 1'b0);
    push_cand(16'hFFFF, -16'sh8000, 1'b1, 1'b0);
    push_cand(16'h0200, 16'sd1, 1'b0, 1'b0);
    push_cand(16'h0200, 16'sd2, 1'b1, 1'b0);
    push_cand(16'h0200, -16'sd1, 1'b0, 1'b0);
    push_cand(16'h0200, -16'sd2, 1'b1, 1'b0);
    push_cand(16'd100, 16'sh0100, 1'b0, 1'b0);
    push_cand(16'd100 + 16'd4095, 16'sh7FFF, 1'b0, 1'b0);
    push_cand(16'd100 + 16'd4096, -16'sh8000, 1'b1, 1'b0);
    push_cand(16'h1234, 16'sd0, 1'b0, 1'b0);
    push_cand(16'h1234 + 16'h0FFF, 16'sh4000, 1'b0, 1'b0);
    push_cand(16'h1234 + 16'h0AAA, -16'sh4000, 1'b0, 1'b0);
    push_cand(16'h1234 + 16'h0555, 16'sh1000, 1'b1, 1'b0);
    push_cand(16'h8000, 16'sd100, 1'b0, 1'b0);
    push_cand(16'h7FFF, -16'sd100, 1'b1, 1'b0);
    // full store; the dropped ones carry the lowest cost and the mark
    for (int j = 0; j < MAX_CANDIDATES; j++)
      push_cand(16'd1000 + 16'($urandom_range(0, 300)), DISP_W'($urandom), 1'b0, 1'b0);
    push_cand(16'h0000, 16'sh7FFF, 1'b0, 1'b0);
    push_cand(16'h0000, -16'sh8000, 1'b1, 1'b0);
    pixels = 9;
    overfull_pixels = 1;

    while (total_cands < 450) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 6);
      else if (r < 90) len = $urandom_range(7, 24);
      else if (r < 97) len = $urandom_range(25, 64);
      else len = $urandom_range(65, 72);
      if (len > MAX_CANDIDATES) overfull_pixels++;
      spread = spread_e'($urandom_range(0, 2));
      base = COST_W'($urandom);
      for (int j = 0; j < len; j++) begin
        case (spread)
          SPREAD_NARROW: cost = base + COST_W'($urandom_range(0, 255));
          SPREAD_EDGE:   cost = base + COST_W'($urandom_range(0, 16'h1100));
          default:       cost = COST_W'($urandom);
        endcase
        push_cand(cost, DISP_W'($urandom), j == len - 1, j == 0 && pixels % 12 == 9);
      end
      pixels++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (pixel_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d candidates over %0d pixels (%0d over capacity), idling on both sides.",
             total_cands, pixels, overfull_pixels);
    $display("Checked %0d results (%0d flagged dropped), %0d mismatches.",
             results_checked, dropped_results, mismatches);
    if (mismatches == 0 && pixel_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
